// ----- design/tlcs_pkg.sv -----
// Package for the tick lead clock sync core: item kinds, register indexes,
// reset values and the constants of the millisecond to tick conversion.
// Depends on nothing; used by tick_lead_clock_sync_core.
package tlcs_pkg;

    // Kinds of input transactions. The fourth code changes nothing.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SNAP  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEAD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd3;

    // Field widths fixed by the interface.
    localparam int unsigned RATE_W  = 10;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CFG_DATA_W = 10;

    // Register reset values; a zero rate is treated as the default rate.
    localparam logic [RATE_W-1:0] RATE_DEFAULT      = 10'd60;
    localparam logic [BYTE_W-1:0] BUF_DEPTH_DEFAULT = 8'd2;
    localparam logic [BYTE_W-1:0] MAX_LEAD_DEFAULT  = 8'd16;
    localparam logic [BYTE_W-1:0] THRESHOLD_DEFAULT = 8'd3;

    // ceil(ms * rate / 1000) is floor((ms * rate + 999) / 1000). The dividend
    // stays below 2^26; a reciprocal of ceil(2^36 / 1000) gives the exact
    // quotient over that whole range.
    localparam int unsigned PROD_W  = WORD_W + RATE_W;
    localparam int unsigned RECIP_W = 27;
    localparam int unsigned RECIP_SHIFT = 36;
    localparam logic [PROD_W-1:0]  ROUND_UP = 26'd999;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;

    // Width of the lead arithmetic before clamping.
    localparam int unsigned LEAD_W = 18;

endpackage

// ----- design/tick_lead_clock_sync_core.sv -----
// Tick lead clock sync core: keeps the client tick a controlled lead ahead
// of the server tick. Depends on tlcs_pkg for kinds, register codes and
// the reciprocal constants of the millisecond to tick conversion.
//
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     kind, server tick, starvation, depth, RTT
// m_        out        m_valid / m_ready     client tick, estimated server tick, leads,
//                                            correction count, synced, snapped
// cfg_      in         cfg_valid / cfg_ready register index and write data
//
// One transaction is accepted per cycle unless a stall at m_ready holds it back.
// Stage one forms ms * rate + 999, stage two divides by 1000 through a
// reciprocal multiply, and stage three applies the item to the sync state and
// loads the result register. Only stage three reads or writes that state, so
// consecutive items see each other's effects without any wait.
// Each stage moves forward when the stage after it is empty or is moving;
// a stall at m_ready backs up through the stages to s_ready.
// aresetn is synchronous and active low. It empties the pipeline, clears the
// sync state and restores the register defaults. The configuration port is
// always ready.
module tick_lead_clock_sync_core #(
    parameter int unsigned TICK_WIDTH = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [TICK_WIDTH-1:0]             s_server_tick,
    input  logic [tlcs_pkg::WORD_W-1:0]       s_starved_ticks,
    input  logic [tlcs_pkg::WORD_W-1:0]       s_buffer_depth,
    input  logic [tlcs_pkg::WORD_W-1:0]       s_round_trip_ms,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [TICK_WIDTH-1:0]             m_client_tick,
    output logic [TICK_WIDTH-1:0]             m_estimated_server_tick,
    output logic [tlcs_pkg::BYTE_W-1:0]       m_current_lead,
    output logic [tlcs_pkg::BYTE_W-1:0]       m_target_lead,
    output logic [tlcs_pkg::COUNT_W-1:0]      m_correction_count,
    output logic                              m_synced,
    output logic                              m_snapped,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tlcs_pkg::*;

    localparam int unsigned MUL_W = PROD_W + RECIP_W;

    // Configuration registers.
    logic [RATE_W-1:0] tick_rate_reg;
    logic [BYTE_W-1:0] buf_depth_reg;
    logic [BYTE_W-1:0] max_lead_reg;
    logic [BYTE_W-1:0] threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg <= RATE_DEFAULT;
            buf_depth_reg <= BUF_DEPTH_DEFAULT;
            max_lead_reg  <= MAX_LEAD_DEFAULT;
            threshold_reg <= THRESHOLD_DEFAULT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TICK_RATE: tick_rate_reg <= cfg_data;
                REG_BUF_DEPTH: buf_depth_reg <= cfg_data[BYTE_W-1:0];
                REG_MAX_LEAD:  max_lead_reg  <= cfg_data[BYTE_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline handshake: a stage loads when it is empty or its content leaves.
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic s1_ready, s2_ready, out_ready;

    assign out_ready = !m_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;
    assign m_valid   = m_valid_reg;

    // Stage one: product of round trip and tick rate, rounded up for the divide.
    logic [RATE_W-1:0] rate_eff;
    logic [PROD_W-1:0] prod_next;

    assign rate_eff  = (tick_rate_reg == '0) ? RATE_DEFAULT : tick_rate_reg;
    assign prod_next = PROD_W'(s_round_trip_ms) * PROD_W'(rate_eff) + ROUND_UP;

    logic [1:0]            s1_kind_reg;
    logic [TICK_WIDTH-1:0] s1_srv_reg;
    logic [WORD_W-1:0]     s1_starved_reg;
    logic [WORD_W-1:0]     s1_depth_reg;
    logic                  s1_ms_nz_reg;
    logic [PROD_W-1:0]     s1_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s1_ready && s_valid) begin
            s1_kind_reg    <= s_kind;
            s1_srv_reg     <= s_server_tick;
            s1_starved_reg <= s_starved_ticks;
            s1_depth_reg   <= s_buffer_depth;
            s1_ms_nz_reg   <= (s_round_trip_ms != '0);
            s1_prod_reg    <= prod_next;
        end
    end

    // Stage two: divide by 1000 through the reciprocal multiply.
    logic [MUL_W-1:0]  quot_full;
    logic [WORD_W-1:0] ticks_next;

    assign quot_full  = MUL_W'(s1_prod_reg) * MUL_W'(RECIP_1000);
    assign ticks_next = quot_full[RECIP_SHIFT +: WORD_W];

    logic [1:0]            s2_kind_reg;
    logic [TICK_WIDTH-1:0] s2_srv_reg;
    logic [WORD_W-1:0]     s2_starved_reg;
    logic [WORD_W-1:0]     s2_depth_reg;
    logic                  s2_ms_nz_reg;
    logic [WORD_W-1:0]     s2_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_kind_reg    <= s1_kind_reg;
            s2_srv_reg     <= s1_srv_reg;
            s2_starved_reg <= s1_starved_reg;
            s2_depth_reg   <= s1_depth_reg;
            s2_ms_nz_reg   <= s1_ms_nz_reg;
            s2_ticks_reg   <= ticks_next;
        end
    end

    // Stage three: the sync state. The estimated server tick is kept directly:
    // it moves with the client tick and is reloaded with the server tick on
    // every snapshot, which equals last server tick plus client ticks since.
    logic [TICK_WIDTH-1:0] client_reg, client_next;
    logic [TICK_WIDTH-1:0] est_reg, est_next;
    logic [BYTE_W-1:0]     lead_now_reg, lead_now_next;
    logic [BYTE_W-1:0]     lead_goal_reg, lead_goal_next;
    logic [COUNT_W-1:0]    snap_total_reg, snap_total_next;
    logic                  synced_reg, synced_next;
    logic                  snapped_next;

    logic [BYTE_W-1:0]     lead_top;
    logic [LEAD_W-1:0]     target_base, target_adj, raised;
    logic [WORD_W-1:0]     excess;
    logic [BYTE_W-1:0]     goal;
    logic [TICK_WIDTH-1:0] ahead;
    logic [BYTE_W-1:0]     measured, drift;
    logic                  do_snap;

    always_comb begin
        lead_top = (max_lead_reg == '0) ? BYTE_W'(1) : max_lead_reg;

        // Target lead: half the round trip in ticks, plus one for any known
        // round trip, one more, and the wanted server-side queue.
        target_base = LEAD_W'(s2_ticks_reg >> 1) + LEAD_W'(s2_ms_nz_reg) + LEAD_W'(1)
                    + LEAD_W'(buf_depth_reg);
        raised      = LEAD_W'(lead_goal_reg) + LEAD_W'(1) + LEAD_W'(s2_starved_reg);
        excess      = s2_depth_reg - WORD_W'(buf_depth_reg);
        target_adj  = target_base;
        if (synced_reg) begin
            if (s2_starved_reg != '0 || s2_depth_reg == '0) begin
                // Starvation or an empty queue: lead at least one past the old goal.
                if (raised > target_adj) begin
                    target_adj = raised;
                end
            end else if (s2_depth_reg > WORD_W'(buf_depth_reg)) begin
                // Too much queued: trim one tick, but only above the excess.
                if (target_adj > LEAD_W'(excess)) begin
                    target_adj = target_adj - LEAD_W'(1);
                end
            end
        end
        if (target_adj == '0) begin
            target_adj = LEAD_W'(1);
        end
        goal = (target_adj > LEAD_W'(lead_top)) ? lead_top : target_adj[BYTE_W-1:0];

        // Measured lead, clamped to the same top, and its drift from the goal.
        ahead    = client_reg - s2_srv_reg;
        measured = '0;
        if (client_reg > s2_srv_reg) begin
            measured = (ahead > TICK_WIDTH'(lead_top)) ? lead_top : ahead[BYTE_W-1:0];
        end
        drift   = (measured > goal) ? (measured - goal) : (goal - measured);
        do_snap = !synced_reg || (drift >= threshold_reg);

        client_next     = client_reg;
        est_next        = est_reg;
        lead_now_next   = lead_now_reg;
        lead_goal_next  = lead_goal_reg;
        snap_total_next = snap_total_reg;
        synced_next     = synced_reg;
        snapped_next    = 1'b0;

        case (s2_kind_reg)
            KIND_TICK: begin
                client_next = client_reg + TICK_WIDTH'(1);
                est_next    = est_reg + TICK_WIDTH'(1);
            end
            KIND_SNAP: begin
                lead_goal_next = goal;
                est_next       = s2_srv_reg;
                synced_next    = 1'b1;
                if (do_snap) begin
                    // The first snapshot is adopted without counting a correction.
                    client_next   = s2_srv_reg + TICK_WIDTH'(goal);
                    lead_now_next = goal;
                    snapped_next  = 1'b1;
                    if (synced_reg) begin
                        snap_total_next = snap_total_reg + COUNT_W'(1);
                    end
                end else begin
                    lead_now_next = measured;
                end
            end
            KIND_CLEAR: begin
                client_next     = '0;
                est_next        = '0;
                lead_now_next   = '0;
                lead_goal_next  = '0;
                snap_total_next = '0;
                synced_next     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    logic adv3;
    assign adv3 = s2_valid_reg && out_ready;

    logic [TICK_WIDTH-1:0] m_client_reg, m_est_reg;
    logic [BYTE_W-1:0]     m_lead_reg, m_target_reg;
    logic [COUNT_W-1:0]    m_count_reg;
    logic                  m_synced_reg, m_snapped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            client_reg     <= '0;
            est_reg        <= '0;
            lead_now_reg   <= '0;
            lead_goal_reg  <= '0;
            snap_total_reg <= '0;
            synced_reg     <= 1'b0;
        end else begin
            if (out_ready) begin
                m_valid_reg <= s2_valid_reg;
            end
            if (adv3) begin
                client_reg     <= client_next;
                est_reg        <= est_next;
                lead_now_reg   <= lead_now_next;
                lead_goal_reg  <= lead_goal_next;
                snap_total_reg <= snap_total_next;
                synced_reg     <= synced_next;
            end
        end
        if (adv3) begin
            m_client_reg  <= client_next;
            m_est_reg     <= synced_next ? est_next : '0;
            m_lead_reg    <= lead_now_next;
            m_target_reg  <= lead_goal_next;
            m_count_reg   <= snap_total_next;
            m_synced_reg  <= synced_next;
            m_snapped_reg <= snapped_next;
        end
    end

    assign m_client_tick           = m_client_reg;
    assign m_estimated_server_tick = m_est_reg;
    assign m_current_lead          = m_lead_reg;
    assign m_target_lead           = m_target_reg;
    assign m_correction_count      = m_count_reg;
    assign m_synced                = m_synced_reg;
    assign m_snapped               = m_snapped_reg;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for tick_lead_clock_sync_core: directed and random
// ticks, snapshots and clears under several register settings.
// Depends on tlcs_pkg and the core RTL only.
module tb_top;
    import tlcs_pkg::*;

    localparam int unsigned TICK_W = 48;
    // The package names three kinds; the fourth code must leave the state alone.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Spare cycles after the last phase catch stray results.
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned PHASE_ITEMS = 78;

    typedef struct {
        logic [1:0]        kind;
        logic [TICK_W-1:0] server_tick;
        logic [WORD_W-1:0] starved;
        logic [WORD_W-1:0] depth;
        logic [WORD_W-1:0] rtt;
    } sync_item_t;

    typedef struct {
        logic [TICK_W-1:0]  client_tick;
        logic [TICK_W-1:0]  est_server_tick;
        logic [BYTE_W-1:0]  cur_lead;
        logic [BYTE_W-1:0]  tgt_lead;
        logic [COUNT_W-1:0] corrections;
        logic               synced;
        logic               snapped;
    } sync_result_t;

    // Mirrors the sync state of the core. Every accepted input transaction is
    // applied here at once and the result it must produce is queued; results
    // leaving the core are checked in order against that queue.
    class sync_scoreboard;
        bit [RATE_W-1:0]  rate_hz;
        bit [BYTE_W-1:0]  buf_goal;
        bit [BYTE_W-1:0]  lead_cap;
        bit [BYTE_W-1:0]  snap_limit;

        bit [TICK_W-1:0]  client_count;
        bit [TICK_W-1:0]  server_seen;
        bit [TICK_W-1:0]  client_at_sync;
        bit [BYTE_W-1:0]  lead_now;
        bit [BYTE_W-1:0]  lead_goal;
        bit [COUNT_W-1:0] snap_total;
        bit               have_sync;

        sync_result_t     due_q[$];
        int unsigned      mismatches;
        int unsigned      checked;

        function new();
            rate_hz    = RATE_DEFAULT;
            buf_goal   = BUF_DEPTH_DEFAULT;
            lead_cap   = MAX_LEAD_DEFAULT;
            snap_limit = THRESHOLD_DEFAULT;
            mismatches = 0;
            checked    = 0;
            clear_sync();
        endfunction

        function void clear_sync();
            client_count   = '0;
            server_seen    = '0;
            client_at_sync = '0;
            lead_now       = '0;
            lead_goal      = '0;
            snap_total     = '0;
            have_sync      = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TICK_RATE: rate_hz    = data;
                REG_BUF_DEPTH: buf_goal   = data[BYTE_W-1:0];
                REG_MAX_LEAD:  lead_cap   = data[BYTE_W-1:0];
                REG_THRESHOLD: snap_limit = data[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(sync_item_t it);
            int unsigned      top;
            int unsigned      rate;
            int unsigned      one_way;
            int unsigned      target;
            int unsigned      raised;
            int unsigned      excess;
            int unsigned      measured;
            int unsigned      drift;
            bit [TICK_W-1:0]  ahead;
            bit               snapped;
            sync_result_t     want;
            snapped = 1'b0;
            case (it.kind)
                KIND_TICK: client_count = client_count + 1'b1;
                KIND_CLEAR: clear_sync();
                KIND_SNAP: begin
                    // A zero cap or rate falls back to the smallest cap and the
                    // default rate.
                    top  = (lead_cap != 0) ? lead_cap : 1;
                    rate = (rate_hz != 0) ? rate_hz : 60;
                    one_way = 0;
                    if (it.rtt != 0)
                        one_way = ((it.rtt * rate + 999) / 1000) / 2 + 1;
                    target = one_way + 1 + buf_goal;
                    if (have_sync) begin
                        if (it.starved != 0 || it.depth == 0) begin
                            raised = lead_goal + 1 + it.starved;
                            if (raised > target)
                                target = raised;
                        end else if (it.depth > buf_goal) begin
                            excess = it.depth - buf_goal;
                            if (target > excess)
                                target = target - 1;
                        end
                    end
                    if (target < 1)
                        target = 1;
                    if (target > top)
                        target = top;
                    lead_goal   = target[BYTE_W-1:0];
                    server_seen = it.server_tick;
                    measured = 0;
                    if (client_count > it.server_tick) begin
                        ahead    = client_count - it.server_tick;
                        measured = (ahead > top) ? top : 32'(ahead);
                    end
                    drift = (measured > target) ? measured - target : target - measured;
                    // The first snapshot is adopted without counting as a correction.
                    if (!have_sync || drift >= snap_limit) begin
                        if (have_sync)
                            snap_total = snap_total + 1'b1;
                        client_count = it.server_tick + target;
                        lead_now     = target[BYTE_W-1:0];
                        have_sync    = 1'b1;
                        snapped      = 1'b1;
                    end else begin
                        lead_now = measured[BYTE_W-1:0];
                    end
                    client_at_sync = client_count;
                end
                default: ;
            endcase
            want.client_tick     = client_count;
            want.est_server_tick = have_sync ? server_seen + (client_count - client_at_sync)
                                             : '0;
            want.cur_lead        = lead_now;
            want.tgt_lead        = lead_goal;
            want.corrections     = snap_total;
            want.synced          = have_sync;
            want.snapped         = snapped;
            due_q.push_back(want);
        endfunction

        function void check_result(sync_result_t got);
            sync_result_t want;
            bit           bad;
            checked = checked + 1;
            if (due_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("result %0d: no result was expected", checked);
                return;
            end
            want = due_q.pop_front();
            bad = (got.client_tick !== want.client_tick)
               || (got.est_server_tick !== want.est_server_tick)
               || (got.cur_lead !== want.cur_lead)
               || (got.tgt_lead !== want.tgt_lead)
               || (got.corrections !== want.corrections)
               || (got.synced !== want.synced)
               || (got.snapped !== want.snapped);
            if (bad) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch (expected / actual):", checked);
                    $display("  client_tick %h / %h  est_server_tick %h / %h",
                             want.client_tick, got.client_tick,
                             want.est_server_tick, got.est_server_tick);
                    $display("  lead %0d / %0d  target %0d / %0d  corrections %0d / %0d",
                             want.cur_lead, got.cur_lead, want.tgt_lead, got.tgt_lead,
                             want.corrections, got.corrections);
                    $display("  synced %b / %b  snapped %b / %b",
                             want.synced, got.synced, want.snapped, got.snapped);
                end
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_kind = '0;
    logic [TICK_W-1:0]     s_server_tick = '0;
    logic [WORD_W-1:0]     s_starved_ticks = '0;
    logic [WORD_W-1:0]     s_buffer_depth = '0;
    logic [WORD_W-1:0]     s_round_trip_ms = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [TICK_W-1:0]     m_client_tick;
    logic [TICK_W-1:0]     m_estimated_server_tick;
    logic [BYTE_W-1:0]     m_current_lead;
    logic [BYTE_W-1:0]     m_target_lead;
    logic [COUNT_W-1:0]    m_correction_count;
    logic                  m_synced;
    logic                  m_snapped;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sync_scoreboard sb;
    bit             quiet_sender = 1'b0;
    int unsigned    cycles = 0;
    int unsigned    sink_wait = 0;
    int unsigned    sink_free = 0;
    int unsigned    sink_seen = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    tick_lead_clock_sync_core #(
        .TICK_WIDTH(TICK_W)
    ) dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_kind                 (s_kind),
        .s_server_tick          (s_server_tick),
        .s_starved_ticks        (s_starved_ticks),
        .s_buffer_depth         (s_buffer_depth),
        .s_round_trip_ms        (s_round_trip_ms),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_client_tick          (m_client_tick),
        .m_estimated_server_tick(m_estimated_server_tick),
        .m_current_lead         (m_current_lead),
        .m_target_lead          (m_target_lead),
        .m_correction_count     (m_correction_count),
        .m_synced               (m_synced),
        .m_snapped              (m_snapped),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data)
    );

    // Gap lengths for both channels: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [TICK_W-1:0] rand_tick();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic sync_item_t make_item(logic [1:0] kind, logic [TICK_W-1:0] srv,
                                             logic [WORD_W-1:0] starved,
                                             logic [WORD_W-1:0] depth,
                                             logic [WORD_W-1:0] rtt);
        sync_item_t it;
        it.kind        = kind;
        it.server_tick = srv;
        it.starved     = starved;
        it.depth       = depth;
        it.rtt         = rtt;
        return it;
    endfunction

    // Offers one input transaction and returns at the edge where it is taken.
    // Valid stays high on return so back-to-back items need no extra edge; the
    // caller lowers it only when it stops sending.
    task automatic send_item(input sync_item_t it);
        int unsigned gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= it.kind;
        s_server_tick   <= it.server_tick;
        s_starved_ticks <= it.starved;
        s_buffer_depth  <= it.depth;
        s_round_trip_ms <= it.rtt;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_input(it);
    endtask

    // Snapshot whose server tick trails the predicted client tick by lead_off
    // ticks; a negative offset puts the server ahead of the client.
    task automatic snap_rel(input int lead_off, input logic [WORD_W-1:0] starved,
                            input logic [WORD_W-1:0] depth, input logic [WORD_W-1:0] rtt);
        logic [TICK_W-1:0] srv;
        srv = TICK_W'(longint'(sb.client_count) - longint'(lead_off));
        send_item(make_item(KIND_SNAP, srv, starved, depth, rtt));
    endtask

    // Stops offering and waits until every queued result has left the core.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_registers(input logic [RATE_W-1:0] rate, input logic [BYTE_W-1:0] bufd,
                                 input logic [BYTE_W-1:0] cap, input logic [BYTE_W-1:0] thr);
        write_reg(REG_TICK_RATE, rate);
        write_reg(REG_BUF_DEPTH, CFG_DATA_W'(bufd));
        write_reg(REG_MAX_LEAD, CFG_DATA_W'(cap));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        cfg_valid <= 1'b0;
    endtask

    // One random transaction. Most snapshots are well formed: the server tick
    // sits near the client tick minus the current lead, and the feedback fields
    // stay close to the buffer goal, so both the hold and snap paths and the
    // raise and trim rules get exercised. The rest is noise.
    task automatic send_random();
        int unsigned       pick;
        int unsigned       r;
        int                lead_off;
        logic [WORD_W-1:0] starved;
        logic [WORD_W-1:0] depth;
        logic [WORD_W-1:0] rtt;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_item(make_item(KIND_TICK, rand_tick(), 16'($urandom), 16'($urandom),
                                16'($urandom)));
        end else if (pick < 82) begin
            lead_off = int'($urandom_range(sb.lead_goal + sb.snap_limit + 4)) - 2;
            r = $urandom_range(99);
            starved = (r < 70) ? 16'd0 : (r < 95) ? 16'($urandom_range(4, 1)) : 16'($urandom);
            r = $urandom_range(99);
            depth = (r < 15) ? 16'd0 : (r < 85) ? 16'(sb.buf_goal + $urandom_range(3))
                                                : 16'($urandom);
            r = $urandom_range(99);
            rtt = (r < 10) ? 16'd0 : (r < 90) ? 16'($urandom_range(400, 1)) : 16'($urandom);
            snap_rel(lead_off, starved, depth, rtt);
        end else if (pick < 91) begin
            send_item(make_item(KIND_SNAP, rand_tick(), 16'($urandom), 16'($urandom),
                                16'($urandom)));
        end else if (pick < 96) begin
            send_item(make_item(KIND_CLEAR, rand_tick(), 16'($urandom), 16'($urandom),
                                16'($urandom)));
        end else begin
            send_item(make_item(KIND_UNUSED, rand_tick(), 16'($urandom), 16'($urandom),
                                16'($urandom)));
        end
    endtask

    // Result side: random stalls, quiet stretches with m_ready held high, and
    // two long hold-offs while the sender keeps offering, so the pipeline
    // fills and s_ready must drop.
    always @(posedge aclk) begin : result_sink
        int unsigned gap;
        if (m_valid && m_ready) begin
            sink_seen = sink_seen + 1;
            if (sink_seen == 150 || sink_seen == 350)
                sink_wait = LONG_HOLD;
        end
        if (sink_wait != 0) begin
            m_ready <= 1'b0;
            sink_wait = sink_wait - 1;
        end else begin
            if (sink_free == 0 && $urandom_range(63) == 0)
                sink_free = 60;
            if (sink_free != 0) begin
                sink_free = sink_free - 1;
                gap = 0;
            end else begin
                gap = pick_gap();
            end
            if (gap == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                sink_wait = gap - 1;
            end
        end
    end

    // Every result taken by the sink is checked against the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        sync_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.client_tick     = m_client_tick;
            got.est_server_tick = m_estimated_server_tick;
            got.cur_lead        = m_current_lead;
            got.tgt_lead        = m_target_lead;
            got.corrections     = m_correction_count;
            got.synced          = m_synced;
            got.snapped         = m_snapped;
            sb.check_result(got);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset register values.
        // A tick before any snapshot must report a zero server estimate, and
        // the unused kind must change nothing even with an all-ones payload.
        send_item(make_item(KIND_TICK, '0, '0, '0, '0));
        send_item(make_item(KIND_UNUSED, '1, '1, '1, '1));
        // The first snapshot is adopted; this one makes the client tick wrap.
        send_item(make_item(KIND_SNAP, {TICK_W{1'b1}} - 1'b1, '0, '0, '0));
        send_item(make_item(KIND_TICK, '0, '0, '0, '0));
        send_item(make_item(KIND_TICK, '0, '0, '0, '0));
        snap_rel(3, 16'd0, 16'd2, 16'd100);
        // Heavy starvation with an empty buffer raises the target into the cap.
        snap_rel(0, 16'hFFFF, 16'd0, 16'hFFFF);
        // An excess larger than the target leaves it alone; a small one trims.
        snap_rel(16, 16'd0, 16'hFFFF, 16'd0);
        snap_rel(5, 16'd0, 16'd3, 16'd0);
        // Client far behind and far ahead of the server.
        snap_rel(-200, 16'd0, 16'd1, 16'd1);
        snap_rel(1000, 16'd1, 16'd0, 16'd999);
        send_item(make_item(KIND_SNAP, '0, '0, 16'd4, '0));
        // A clear drops back to unsynced; the next snapshot is adopted again.
        send_item(make_item(KIND_CLEAR, '1, '1, '1, '1));
        send_item(make_item(KIND_SNAP, '1, 16'h5555, 16'hAAAA, 16'd1));
        send_item(make_item(KIND_TICK, '0, '0, '0, '0));
        wait_idle();

        // Zero rate, zero cap and zero threshold, with the largest buffer goal.
        set_registers(10'd0, 8'd255, 8'd0, 8'd0);
        snap_rel(0, 16'd0, 16'd5, 16'hFFFF);
        snap_rel(1, 16'd0, 16'd255, 16'd7);
        send_item(make_item(KIND_TICK, '0, '0, '0, '0));
        snap_rel(1, 16'd2, 16'd300, 16'd0);
        wait_idle();

        // Random phases, each under its own register setting; the sender waits
        // for the core to drain before every change.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_registers(10'd1000, 8'd255, 8'd255, 8'd255);
                1: set_registers(10'd1, 8'd0, 8'd1, 8'd1);
                2: set_registers(10'd0, 8'd3, 8'd0, 8'd0);
                3: set_registers(RATE_DEFAULT, BUF_DEPTH_DEFAULT, MAX_LEAD_DEFAULT,
                                 THRESHOLD_DEFAULT);
                4: set_registers(10'($urandom_range(1000, 1)), 8'($urandom_range(20)),
                                 8'($urandom_range(64, 4)), 8'($urandom_range(8, 1)));
                default: set_registers(10'd144, 8'd5, 8'd40, 8'd2);
            endcase
            // One phase offers items back to back with no sender gaps.
            quiet_sender = (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/tlcs_pkg.sv
design/tick_lead_clock_sync_core.sv
sim/tb_top.sv
